[rtl/tmfq_pkg.sv]
// Shared types and constants for the touch multi-feature qualifier.
// Used by the configuration register file, the run/hold feature unit and the top level.
`default_nettype none

package tmfq_pkg;

  localparam int unsigned SumBits   = 20;
  localparam int unsigned RunBits   = 8;
  localparam int unsigned InBits    = 16;
  localparam int unsigned EvtBits   = 2;
  localparam int unsigned AddrBits  = 5;
  localparam int unsigned DataBits  = 32;

  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};
  localparam logic [RunBits-1:0] RunMax = {RunBits{1'b1}};

  // Result event codes
  localparam logic [EvtBits-1:0] EvtNone  = 2'd0;
  localparam logic [EvtBits-1:0] EvtTouch = 2'd1;
  localparam logic [EvtBits-1:0] EvtStuck = 2'd2;

  // Register indexes (byte address is four times the index)
  typedef enum logic [2:0] {
    RegSumThreshold   = 3'd0,
    RegSumRunNeeded   = 3'd1,
    RegLevelThreshold = 3'd2,
    RegLevelRunNeeded = 3'd3,
    RegHighThreshold  = 3'd4,
    RegMaxTouchRun    = 3'd5,
    RegStuckRun       = 3'd6,
    RegHoldSteps      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SumBits-1:0] sum_threshold;
    logic [RunBits-1:0] sum_run_needed;
    logic [InBits-1:0]  level_threshold;
    logic [RunBits-1:0] level_run_needed;
    logic [InBits-1:0]  high_threshold;
    logic [RunBits-1:0] max_touch_run;
    logic [RunBits-1:0] stuck_run;
    logic [RunBits-1:0] hold_steps;
  } cfg_t;

  // Status of one run/hold feature for the current step
  typedef struct packed {
    logic hold_live;   // hold nonzero after arming, before the countdown
    logic armed;       // hold nonzero after the countdown
  } feat_status_t;

endpackage

`default_nettype wire

[rtl/tmfq_cfg.sv]
// APB-style configuration register file for the touch qualifier.
// Depends on tmfq_pkg for the register index enum and the cfg_t bundle.
`default_nettype none

module tmfq_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmfq_pkg::AddrBits-1:0] paddr,
  input  wire logic [tmfq_pkg::DataBits-1:0] pwdata,
  output logic      [tmfq_pkg::DataBits-1:0] prdata,
  output logic                               pready,
  output tmfq_pkg::cfg_t                     cfg_o
);

  tmfq_pkg::cfg_t     cfg_q;
  tmfq_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = tmfq_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sum_threshold    <= 20'd55;
      cfg_q.sum_run_needed   <= 8'd1;
      cfg_q.level_threshold  <= 16'd16;
      cfg_q.level_run_needed <= 8'd2;
      cfg_q.high_threshold   <= 16'd10;
      cfg_q.max_touch_run    <= 8'd10;
      cfg_q.stuck_run        <= 8'd25;
      cfg_q.hold_steps       <= 8'd4;
    end else if (wr_en) begin
      unique case (idx)
        tmfq_pkg::RegSumThreshold:   cfg_q.sum_threshold    <= pwdata[19:0];
        tmfq_pkg::RegSumRunNeeded:   cfg_q.sum_run_needed   <= pwdata[7:0];
        tmfq_pkg::RegLevelThreshold: cfg_q.level_threshold  <= pwdata[15:0];
        tmfq_pkg::RegLevelRunNeeded: cfg_q.level_run_needed <= pwdata[7:0];
        tmfq_pkg::RegHighThreshold:  cfg_q.high_threshold   <= pwdata[15:0];
        tmfq_pkg::RegMaxTouchRun:    cfg_q.max_touch_run    <= pwdata[7:0];
        tmfq_pkg::RegStuckRun:       cfg_q.stuck_run        <= pwdata[7:0];
        tmfq_pkg::RegHoldSteps:      cfg_q.hold_steps       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tmfq_pkg::RegSumThreshold:   prdata = {12'd0, cfg_q.sum_threshold};
      tmfq_pkg::RegSumRunNeeded:   prdata = {24'd0, cfg_q.sum_run_needed};
      tmfq_pkg::RegLevelThreshold: prdata = {16'd0, cfg_q.level_threshold};
      tmfq_pkg::RegLevelRunNeeded: prdata = {24'd0, cfg_q.level_run_needed};
      tmfq_pkg::RegHighThreshold:  prdata = {16'd0, cfg_q.high_threshold};
      tmfq_pkg::RegMaxTouchRun:    prdata = {24'd0, cfg_q.max_touch_run};
      tmfq_pkg::RegStuckRun:       prdata = {24'd0, cfg_q.stuck_run};
      tmfq_pkg::RegHoldSteps:      prdata = {24'd0, cfg_q.hold_steps};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/tmfq_feature.sv]
// One run/hold feature: a saturating run counter that arms a hold countdown.
// Depends on tmfq_pkg for widths and the feat_status_t bundle.
`default_nettype none

module tmfq_feature (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic                         clear_i,
  input  wire logic                         qualify_i,
  input  wire logic [tmfq_pkg::RunBits-1:0] needed_i,
  input  wire logic [tmfq_pkg::RunBits-1:0] hold_steps_i,
  output tmfq_pkg::feat_status_t            status_o
);

  logic [tmfq_pkg::RunBits-1:0] run_q, run_d, run_inc;
  logic [tmfq_pkg::RunBits-1:0] hold_q, hold_mid, hold_d;

  always_comb begin
    run_inc  = (run_q == tmfq_pkg::RunMax) ? run_q : run_q + 8'd1;
    run_d    = '0;
    hold_mid = hold_q;
    if (qualify_i) begin
      if (run_inc >= needed_i) begin
        // Once the run reaches its needed length it is clamped there.
        run_d    = needed_i;
        hold_mid = hold_steps_i;
      end else begin
        run_d = run_inc;
      end
    end
    hold_d = (hold_mid != '0) ? hold_mid - 8'd1 : '0;
  end

  assign status_o.hold_live = (hold_mid != '0);
  assign status_o.armed     = (hold_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      hold_q <= '0;
    end else if (step_i) begin
      if (clear_i) begin
        run_q  <= '0;
        hold_q <= '0;
      end else begin
        run_q  <= run_d;
        hold_q <= hold_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/touch_multi_feature_qualifier_top.sv]
// Touch multi-feature qualifier: an input register, combinational window and feature logic,
// and a result register. Throughput one request per cycle unless the result stalls.
// A new request is taken while a finished result waits, as long as the input register is free.
// Reset is asynchronous and active low; it loads the register defaults and clears the window,
// the running sum, the run counters and the holds. No clearing pass is needed after reset.
`default_nettype none

module touch_multi_feature_qualifier_top #(
  parameter int unsigned WINDOW_LENGTH = 5,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tmfq_pkg::InBits-1:0]   sample_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [tmfq_pkg::EvtBits-1:0]  event_res_o,
  output logic      [tmfq_pkg::SumBits-1:0]  window_sum_o,
  output logic                               sum_armed_o,
  output logic                               level_armed_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmfq_pkg::AddrBits-1:0] paddr,
  input  wire logic [tmfq_pkg::DataBits-1:0] pwdata,
  output logic      [tmfq_pkg::DataBits-1:0] prdata,
  output logic                               pready
);

  // Only the low SAMPLE_BITS bits of a sample take part, and never more than the port carries.
  localparam int unsigned StoreBits =
      (SAMPLE_BITS < tmfq_pkg::InBits) ? SAMPLE_BITS : tmfq_pkg::InBits;
  localparam int unsigned PtrBits   =
      (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam logic [PtrBits-1:0] LastSlot = PtrBits'(WINDOW_LENGTH - 1);

  tmfq_pkg::cfg_t cfg;

  tmfq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Handshake. The input register holds one request; it moves into the result
  // register whenever that register is empty or its result is being taken.
  // The input side stalls only when a request is held and cannot move on.
  // ---------------------------------------------------------------------------
  logic                         in_valid_q;
  logic [tmfq_pkg::InBits-1:0]  sample_q;
  logic                         advance;
  logic                         step;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sample_q <= sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample window and running sum. The pointer moves first; the slot it then
  // names holds the oldest sample, which leaves the sum before the new one
  // enters. If the oldest sample exceeds the sum, the sum floors at zero.
  // ---------------------------------------------------------------------------
  logic [StoreBits-1:0]          window_q [WINDOW_LENGTH];
  logic [PtrBits-1:0]            ptr_q, ptr_d;
  logic [tmfq_pkg::SumBits-1:0]  sum_q, sum_d, sum_less;
  logic [tmfq_pkg::SumBits:0]    sum_wide;
  logic [StoreBits-1:0]          s_cut;
  logic [tmfq_pkg::SumBits-1:0]  s_sum, old_sum;
  logic [tmfq_pkg::InBits-1:0]   s_full;

  assign s_cut   = sample_q[StoreBits-1:0];
  assign s_sum   = tmfq_pkg::SumBits'(s_cut);
  assign s_full  = tmfq_pkg::InBits'(s_cut);
  assign ptr_d   = (ptr_q == LastSlot) ? '0 : ptr_q + 1'b1;
  assign old_sum = tmfq_pkg::SumBits'(window_q[ptr_d]);

  always_comb begin
    sum_less = (sum_q >= old_sum) ? sum_q - old_sum : '0;
    sum_wide = {1'b0, sum_less} + {1'b0, s_sum};
    // The sum saturates at its full scale.
    sum_d    = sum_wide[tmfq_pkg::SumBits] ? tmfq_pkg::SumMax
                                           : sum_wide[tmfq_pkg::SumBits-1:0];
  end

  // ---------------------------------------------------------------------------
  // Features. The sum and level features arm their holds; the high run decides
  // the events. A touch needs a low sample ending a short high run while both
  // holds are live; a stuck sensor needs a high run reaching its limit.
  // ---------------------------------------------------------------------------
  tmfq_pkg::feat_status_t        sum_st, level_st;
  logic [tmfq_pkg::RunBits-1:0]  high_q, high_inc;
  logic                          high_hit;
  logic [tmfq_pkg::EvtBits-1:0]  evt;
  logic                          clear;

  assign high_hit = (s_full >= cfg.high_threshold);
  assign high_inc = (high_q == tmfq_pkg::RunMax) ? high_q : high_q + 8'd1;

  always_comb begin
    evt = tmfq_pkg::EvtNone;
    if (high_hit) begin
      if (high_inc >= cfg.stuck_run) begin
        evt = tmfq_pkg::EvtStuck;
      end
    end else if (high_q <= cfg.max_touch_run && sum_st.hold_live && level_st.hold_live) begin
      evt = tmfq_pkg::EvtTouch;
    end
  end

  assign clear = (evt != tmfq_pkg::EvtNone);

  tmfq_feature u_sum_feat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .clear_i      (clear),
    .qualify_i    (sum_d >= cfg.sum_threshold),
    .needed_i     (cfg.sum_run_needed),
    .hold_steps_i (cfg.hold_steps),
    .status_o     (sum_st)
  );

  tmfq_feature u_level_feat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .clear_i      (clear),
    .qualify_i    (s_full >= cfg.level_threshold),
    .needed_i     (cfg.level_run_needed),
    .hold_steps_i (cfg.hold_steps),
    .status_o     (level_st)
  );

  // Window, pointer, sum and high run. An event returns all of them to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        window_q[i] <= '0;
      end
      ptr_q  <= LastSlot;
      sum_q  <= '0;
      high_q <= '0;
    end else if (step) begin
      if (clear) begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
          window_q[i] <= '0;
        end
        ptr_q  <= LastSlot;
        sum_q  <= '0;
        high_q <= '0;
      end else begin
        window_q[ptr_d] <= s_cut;
        ptr_q           <= ptr_d;
        sum_q           <= sum_d;
        high_q          <= high_hit ? high_inc : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It shows the values from before any event reset.
  // ---------------------------------------------------------------------------
  logic                         out_valid_q;
  logic [tmfq_pkg::EvtBits-1:0] event_res_q;
  logic [tmfq_pkg::SumBits-1:0] window_sum_q;
  logic                         sum_armed_q;
  logic                         level_armed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_res_q   <= evt;
      window_sum_q  <= sum_d;
      sum_armed_q   <= sum_st.armed;
      level_armed_q <= level_st.armed;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = event_res_q;
  assign window_sum_o  = window_sum_q;
  assign sum_armed_o   = sum_armed_q;
  assign level_armed_o = level_armed_q;

endmodule

`default_nettype wire

[rtl/tmfq_checker.sv]
// Port-level checker for the touch qualifier, attached to the top level by bind.
// Depends on tmfq_pkg for widths and event codes.
`default_nettype none

module tmfq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [tmfq_pkg::EvtBits-1:0] event_res_o,
  input wire logic [tmfq_pkg::SumBits-1:0] window_sum_o,
  input wire logic                         sum_armed_o,
  input wire logic                         level_armed_o
);

  // A result waiting to be taken holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
      $stable(window_sum_o) && $stable(sum_armed_o) && $stable(level_armed_o))
    else $error("result changed while stalled");

  // Only the three defined event codes are ever reported.
  a_evt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o == tmfq_pkg::EvtNone ||
      event_res_o == tmfq_pkg::EvtTouch || event_res_o == tmfq_pkg::EvtStuck))
    else $error("undefined event code");

  // The input side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // A result appearing from an empty output follows a request taken through the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a request");

endmodule

bind touch_multi_feature_qualifier_top tmfq_checker u_tmfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .event_res_o   (event_res_o),
  .window_sum_o  (window_sum_o),
  .sum_armed_o   (sum_armed_o),
  .level_armed_o (level_armed_o)
);

`default_nettype wire

[test/tmfq_tb_pkg.sv]
// Scoreboard for the touch multi-feature qualifier testbench: a step-by-step model of the
// qualifier and the queue of reports that the block still owes.
// Depends on tmfq_pkg for widths, event codes, register indexes and the register record.
package tmfq_tb_pkg;
  import tmfq_pkg::*;

  localparam int WindowLength = 5;

  typedef struct packed {
    logic [EvtBits-1:0] event_res;
    logic [SumBits-1:0] window_sum;
    logic               sum_armed;
    logic               level_armed;
  } touch_report_t;

  class touch_report_scoreboard;
    cfg_t              cfg;
    logic [InBits-1:0] window[WindowLength];
    int                slot;
    logic [SumBits-1:0] window_total;
    logic [RunBits-1:0] sum_run, level_run, high_run, sum_hold, level_hold;
    touch_report_t     awaited_reports[$];
    int unsigned       mismatches, reports_seen, touches_seen, stucks_seen;

    function new();
      cfg.sum_threshold    = 20'd55;
      cfg.sum_run_needed   = 8'd1;
      cfg.level_threshold  = 16'd16;
      cfg.level_run_needed = 8'd2;
      cfg.high_threshold   = 16'd10;
      cfg.max_touch_run    = 8'd10;
      cfg.stuck_run        = 8'd25;
      cfg.hold_steps       = 8'd4;
      mismatches   = 0;
      reports_seen = 0;
      touches_seen = 0;
      stucks_seen  = 0;
      clear_feature_state();
    endfunction

    function void clear_feature_state();
      foreach (window[i]) window[i] = '0;
      slot         = WindowLength - 1;
      window_total = '0;
      sum_run      = '0;
      level_run    = '0;
      high_run     = '0;
      sum_hold     = '0;
      level_hold   = '0;
    endfunction

    function logic [RunBits-1:0] bump_run(logic [RunBits-1:0] r);
      return (r == RunMax) ? RunMax : r + 1'b1;
    endfunction

    // Register values are cut to the width of the register.
    function void set_register(reg_idx_e idx, logic [DataBits-1:0] value);
      case (idx)
        RegSumThreshold:   cfg.sum_threshold    = value[SumBits-1:0];
        RegSumRunNeeded:   cfg.sum_run_needed   = value[RunBits-1:0];
        RegLevelThreshold: cfg.level_threshold  = value[InBits-1:0];
        RegLevelRunNeeded: cfg.level_run_needed = value[RunBits-1:0];
        RegHighThreshold:  cfg.high_threshold   = value[InBits-1:0];
        RegMaxTouchRun:    cfg.max_touch_run    = value[RunBits-1:0];
        RegStuckRun:       cfg.stuck_run        = value[RunBits-1:0];
        RegHoldSteps:      cfg.hold_steps       = value[RunBits-1:0];
        default: ;
      endcase
    endfunction

    function touch_report_t qualify_sample(logic [InBits-1:0] s);
      touch_report_t     r;
      logic [SumBits:0]  acc;
      logic [EvtBits-1:0] evt;
      evt  = EvtNone;
      slot = (slot == WindowLength - 1) ? 0 : slot + 1;
      // The slot being replaced leaves the sum; the sum floors at zero.
      if (window_total >= window[slot]) window_total = window_total - window[slot];
      else window_total = '0;
      acc = {1'b0, window_total} + s;
      window_total = (acc > SumMax) ? SumMax : acc[SumBits-1:0];
      window[slot] = s;

      if (window_total >= cfg.sum_threshold) begin
        sum_run = bump_run(sum_run);
        if (sum_run >= cfg.sum_run_needed) begin
          sum_hold = cfg.hold_steps;
          sum_run  = cfg.sum_run_needed;
        end
      end else begin
        sum_run = '0;
      end

      if (s >= cfg.level_threshold) begin
        level_run = bump_run(level_run);
        if (level_run >= cfg.level_run_needed) begin
          level_hold = cfg.hold_steps;
          level_run  = cfg.level_run_needed;
        end
      end else begin
        level_run = '0;
      end

      if (s >= cfg.high_threshold) begin
        high_run = bump_run(high_run);
        if (high_run >= cfg.stuck_run) evt = EvtStuck;
      end else begin
        if (high_run <= cfg.max_touch_run && sum_hold != 0 && level_hold != 0) evt = EvtTouch;
        high_run = '0;
      end

      if (sum_hold != 0) sum_hold = sum_hold - 1'b1;
      if (level_hold != 0) level_hold = level_hold - 1'b1;

      r.event_res   = evt;
      r.window_sum  = window_total;
      r.sum_armed   = (sum_hold != 0);
      r.level_armed = (level_hold != 0);
      // The report shows the state from before the clear.
      if (evt != EvtNone) clear_feature_state();
      return r;
    endfunction

    function void note_sample(logic [InBits-1:0] s);
      awaited_reports.push_back(qualify_sample(s));
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    function void check_report(touch_report_t got);
      touch_report_t want;
      reports_seen++;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report with no sample pending: event %0d sum %0d armed %0b/%0b",
                   got.event_res, got.window_sum, got.sum_armed, got.level_armed);
        return;
      end
      want = awaited_reports.pop_front();
      if (want.event_res == EvtTouch) touches_seen++;
      if (want.event_res == EvtStuck) stucks_seen++;
      if (got.event_res !== want.event_res || got.window_sum !== want.window_sum ||
          got.sum_armed !== want.sum_armed || got.level_armed !== want.level_armed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d differs: event %0d/%0d sum %0d/%0d sum_armed %0b/%0b level_armed %0b/%0b (expected/actual)",
                   reports_seen, want.event_res, got.event_res, want.window_sum, got.window_sum,
                   want.sum_armed, got.sum_armed, want.level_armed, got.level_armed);
      end
    endfunction
  endclass

endpackage

[test/tb_touch_multi_feature_qualifier_top.sv]
// Top-level testbench for the touch multi-feature qualifier: drives samples and register
// writes, and checks every report against the scoreboard in tmfq_tb_pkg.
// Depends on tmfq_pkg, tmfq_tb_pkg and the RTL top level touch_multi_feature_qualifier_top.
module tb_touch_multi_feature_qualifier_top;
  import tmfq_pkg::*;
  import tmfq_tb_pkg::*;

  // A request passes the input register and then the result register, so this settle wait is
  // plenty to be sure that the block has gone quiet.
  localparam int SettleCycles = 8;
  // Longest stretch without any request moving before the run is declared hung.
  localparam int QuietLimit   = 1000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic [InBits-1:0]   sample      = '0;
  logic                out_stall   = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [DataBits-1:0] pwdata      = '0;
  logic                in_stall;
  logic                out_valid;
  logic [EvtBits-1:0]  event_res;
  logic [SumBits-1:0]  window_sum;
  logic                sum_armed;
  logic                level_armed;
  logic [DataBits-1:0] prdata;
  logic                pready;

  touch_report_scoreboard sb;

  int burst_left     = 0;
  int samples_sent   = 0;
  int settings_used  = 0;
  int stall_left     = 0;
  int stall_mode     = 0;
  int quiet_cycles   = 0;

  always #2 clk = ~clk;

  touch_multi_feature_qualifier_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_res_o  (event_res),
    .window_sum_o (window_sum),
    .sum_armed_o  (sum_armed),
    .level_armed_o(level_armed),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // The receiver stalls on a pattern of its own that changes every so often: no stall at
  // all, light random stalling, heavy random stalling, or long regular stretches of stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 1) == 0);
      end
      default: begin
        out_stall <= ((stall_left % 16) < 9);
      end
    endcase
  end

  // Every accepted report goes to the scoreboard. The watchdog counts the cycles in which no
  // request moves on either channel and gives up once the count reaches its limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_report({event_res, window_sum, sum_armed, level_armed});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("no request moved for %0d cycles", QuietLimit);
        $display("tb_touch_multi_feature_qualifier_top: FAIL");
        $finish;
      end
    end
  end

  // The sender works in bursts of random length. Between bursts it drops valid for a random
  // gap, though now and then a burst follows straight on. The sample is noted in the
  // scoreboard at the edge where the request is taken.
  task automatic send_sample(input logic [InBits-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
    samples_sent++;
  endtask

  // Holds the sender back until every report owed has come out.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drains the block and then waits a little longer, so that a register write cannot land
  // while a sample is still on its way through.
  task automatic quiesce();
    drain_reports();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One register write: a setup cycle, then an access cycle at whose closing edge the
  // register takes the value, then an idle cycle. The scoreboard copy changes with it.
  task automatic apb_write(input reg_idx_e idx, input logic [DataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // Fills the bits above a register's width with junk, which the block must discard.
  function automatic logic [DataBits-1:0] with_junk(input logic [DataBits-1:0] value,
                                                    input int bits);
    logic [DataBits-1:0] mask;
    logic [DataBits-1:0] junk;
    mask = (32'h1 << bits) - 32'h1;
    junk = $urandom;
    return (junk & ~mask) | (value & mask);
  endfunction

  task automatic write_settings(input cfg_t c);
    quiesce();
    apb_write(RegSumThreshold,   with_junk(c.sum_threshold, SumBits));
    apb_write(RegSumRunNeeded,   with_junk(c.sum_run_needed, RunBits));
    apb_write(RegLevelThreshold, with_junk(c.level_threshold, InBits));
    apb_write(RegLevelRunNeeded, with_junk(c.level_run_needed, RunBits));
    apb_write(RegHighThreshold,  with_junk(c.high_threshold, InBits));
    apb_write(RegMaxTouchRun,    with_junk(c.max_touch_run, RunBits));
    apb_write(RegStuckRun,       with_junk(c.stuck_run, RunBits));
    apb_write(RegHoldSteps,      with_junk(c.hold_steps, RunBits));
    settings_used++;
  endtask

  // Settings in a range where touches, stuck reports and near misses all turn up often.
  function automatic cfg_t random_settings();
    cfg_t c;
    logic [31:0] v;
    v = $urandom_range(0, 3000);  c.sum_threshold    = v[SumBits-1:0];
    v = $urandom_range(1, 5);     c.sum_run_needed   = v[RunBits-1:0];
    v = $urandom_range(0, 1500);  c.level_threshold  = v[InBits-1:0];
    v = $urandom_range(1, 5);     c.level_run_needed = v[RunBits-1:0];
    v = $urandom_range(1, 1500);  c.high_threshold   = v[InBits-1:0];
    v = $urandom_range(0, 15);    c.max_touch_run    = v[RunBits-1:0];
    v = $urandom_range(1, 40);    c.stuck_run        = v[RunBits-1:0];
    v = $urandom_range(1, 12);    c.hold_steps       = v[RunBits-1:0];
    return c;
  endfunction

  // A sample that extends the high run and counts for the level feature. Half the time it
  // is also at least half the sum threshold, rounded down.
  function automatic logic [InBits-1:0] pick_high();
    int unsigned lo;
    int unsigned hi;
    logic [31:0] v;
    lo = sb.cfg.high_threshold;
    if (sb.cfg.level_threshold > lo) lo = sb.cfg.level_threshold;
    if ($urandom_range(0, 1) == 1 && sb.cfg.sum_threshold / 2 > lo) lo = sb.cfg.sum_threshold / 2;
    if (lo > 65535) lo = 65535;
    hi = lo + $urandom_range(0, 400);
    if (hi > 65535) hi = 65535;
    v = $urandom_range(lo, hi);
    return v[InBits-1:0];
  endfunction

  // A sample that ends the high run; with a high threshold of zero there is none.
  function automatic logic [InBits-1:0] pick_low();
    logic [31:0] v;
    if (sb.cfg.high_threshold == 0) return '0;
    v = $urandom_range(0, sb.cfg.high_threshold - 1);
    return v[InBits-1:0];
  endfunction

  function automatic logic [InBits-1:0] pick_any();
    logic [31:0] v;
    v = $urandom_range(0, 65535);
    return v[InBits-1:0];
  endfunction

  // Random part of a phase. Most of it is touch attempts: a short high run of random length
  // followed by a few low samples, which is what gets both holds armed and a touch out.
  // Some is long high runs that end in a stuck report, some is plain noise over the whole
  // range, and once in a while the sender waits for the block to empty.
  task automatic run_random(input int budget);
    int sent_here;
    int kind;
    int n;
    int lows;
    sent_here = 0;
    while (sent_here < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        n = sb.cfg.max_touch_run + 3;
        if (n > 40) n = 40;
        n = $urandom_range(1, n);
        lows = $urandom_range(1, 3);
        repeat (n) send_sample(pick_high());
        repeat (lows) send_sample(pick_low());
        sent_here += n + lows;
      end else if (kind < 72) begin
        n = sb.cfg.stuck_run + 1;
        repeat (n) send_sample(pick_high());
        sent_here += n;
      end else if (kind < 98) begin
        n = $urandom_range(1, 8);
        repeat (n) send_sample(pick_any());
        sent_here += n;
      end else begin
        drain_reports();
      end
    end
  endtask

  initial begin
    cfg_t c;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings. A fresh touch first: two level samples arm both features and the low
    // sample after them ends a short high run. Then the sample extremes and alternating bits.
    settings_used++;
    send_sample(16'd30);
    send_sample(16'd30);
    send_sample(16'd5);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    run_random(150);

    // Every register at its top value: the sum threshold cannot be reached, and only a run
    // of full-scale samples gets to the stuck length.
    c = '1;
    write_settings(c);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    run_random(200);

    // Every register at its bottom value: each sample is high and reports stuck at once.
    c.sum_threshold    = '0;
    c.sum_run_needed   = 8'd1;
    c.level_threshold  = '0;
    c.level_run_needed = 8'd1;
    c.high_threshold   = '0;
    c.max_touch_run    = '0;
    c.stuck_run        = 8'd1;
    c.hold_steps       = 8'd1;
    write_settings(c);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    run_random(150);

    // Zero run lengths: a needed length of zero arms on the first qualifying step and keeps
    // the run at zero, and a stuck length of zero reports stuck on any high sample. The
    // first sample here arms both features and reports a touch in the same step.
    c.sum_threshold    = 20'd60;
    c.sum_run_needed   = '0;
    c.level_threshold  = 16'd50;
    c.level_run_needed = '0;
    c.high_threshold   = 16'd100;
    c.max_touch_run    = 8'd5;
    c.stuck_run        = '0;
    c.hold_steps       = 8'd3;
    write_settings(c);
    send_sample(16'd60);
    send_sample(16'd0);
    send_sample(16'd120);
    send_sample(16'd5);
    run_random(150);

    repeat (5) begin
      write_settings(random_settings());
      run_random(220);
    end

    quiesce();
    $display("Sent %0d samples and checked %0d reports (%0d touches, %0d stuck)",
             samples_sent, sb.reports_seen, sb.touches_seen, sb.stucks_seen);
    $display("over %0d register settings.", settings_used);
    $display("Mismatches: %0d, reports still owed: %0d.", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_touch_multi_feature_qualifier_top: PASS");
    end else begin
      $display("tb_touch_multi_feature_qualifier_top: FAIL");
    end
    $finish;
  end

endmodule
